// ===== rtl/core/fixed_chunk_free_list_allocator_top_macros.svh =====
// Assertion helpers for the chunk allocator.
// Each expects i_clk and i_rst_n in scope.
`ifndef FIXED_CHUNK_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_CHUNK_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH

// prop must hold at every edge out of reset
`define FCFL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// cond must never be true out of reset
`define FCFL_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/fcfl_pkg.sv =====
package fcfl_pkg;

    localparam int CHUNK_BYTES    = 4096;
    localparam int CHUNK_SHIFT    = $clog2(CHUNK_BYTES);
    localparam int MAX_CHUNKS_DEF = 1024;

    localparam logic [31:0] ALIGN_MASK = ~(32'(CHUNK_BYTES) - 32'd1);
    localparam logic [31:0] LOW_MASK   = 32'(CHUNK_BYTES) - 32'd1;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_FREE  = 3'd1,
        ST_BAD_SIZE = 3'd2,
        ST_NULL     = 3'd3,
        ST_BAD_ADDR = 3'd4
    } t_status;

    localparam logic CFG_HEAP_START = 1'b0;
    localparam logic CFG_HEAP_END   = 1'b1;

    typedef struct packed {
        logic load;   // capture the input beat
        logic exec;   // apply the operation to list state
        logic walk;   // write one link of the init sweep
        logic emit;   // load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic is_init;
        logic walk_done;
    } t_dp_stat;

endpackage

// ===== rtl/core/fcfl_ram.sv =====
module fcfl_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/fcfl_dp.sv =====
module fcfl_dp import fcfl_pkg::*; #(
    parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [31:0]                     i_cfg_wdata,
    input  logic [1:0]                      i_opcode,
    input  logic [31:0]                     i_request_size,
    input  logic [31:0]                     i_release_addr,
    input  t_dp_cmd                         i_cmd,
    output t_dp_stat                        o_stat,
    output logic [31:0]                     o_chunk_addr,
    output logic [2:0]                      o_status,
    output logic [$clog2(MAX_CHUNKS+1)-1:0] o_free_count
);

    localparam int IW = $clog2(MAX_CHUNKS);
    localparam int CW = $clog2(MAX_CHUNKS + 1);

    logic [31:0]   r_start, r_end;
    t_op           r_op;
    logic [31:0]   r_size, r_addr;
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_free, n_free;
    logic [CW-1:0] r_in_use, n_in_use;
    logic [31:0]   r_base, n_base;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [31:0]   r_out_addr;
    logic [2:0]    r_out_status;
    logic [CW-1:0] r_out_free;

    logic [31:0]   len, nraw, off, idx32;
    logic [CW-1:0] n_init, cnt_inc;
    logic [IW-1:0] link_val, rdata;
    logic          free_bad, alloc_ok, free_ok;
    t_status       res_status;
    logic          mem_we;
    logic [IW-1:0] mem_waddr, mem_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEAP_START: r_start <= i_cfg_wdata;
                CFG_HEAP_END:   r_end   <= i_cfg_wdata;
                default:        r_start <= r_start;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_opcode);
            r_size <= i_request_size;
            r_addr <= i_release_addr;
        end
        if (i_cmd.emit) begin
            r_out_addr   <= (alloc_ok && (r_op == OP_ALLOC))
                            ? r_base + (32'(r_head) << CHUNK_SHIFT) : 32'd0;
            r_out_status <= res_status;
            r_out_free   <= n_free;
        end
        r_cnt <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_free   <= '0;
            r_in_use <= '0;
            r_base   <= '0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_free   <= n_free;
            r_in_use <= n_in_use;
            r_base   <= n_base;
        end
    end

    // init geometry: aligned length in chunks, saturated
    always_comb begin
        len    = (r_end - r_start) & ALIGN_MASK;
        nraw   = len >> CHUNK_SHIFT;
        n_init = (nraw > 32'(MAX_CHUNKS)) ? CW'(MAX_CHUNKS) : nraw[CW-1:0];
    end

    // free address decode; offset wraps mod 2^32
    always_comb begin
        off      = r_addr - r_base;
        idx32    = off >> CHUNK_SHIFT;
        free_bad = ((off & LOW_MASK) != 32'd0) || (idx32 >= 32'(r_in_use))
                   || (idx32 >= 32'(MAX_CHUNKS));
    end

    always_comb begin
        res_status = ST_OK;
        alloc_ok   = 1'b0;
        free_ok    = 1'b0;
        case (r_op)
            OP_ALLOC: begin
                if (r_free == '0) begin
                    res_status = ST_NO_FREE;
                end else if (r_size[31] || (r_size > 32'(CHUNK_BYTES))) begin
                    res_status = ST_BAD_SIZE;
                end else begin
                    alloc_ok = 1'b1;
                end
            end
            OP_FREE: begin
                if (r_addr == 32'd0) begin
                    res_status = ST_NULL;
                end else if (free_bad) begin
                    res_status = ST_BAD_ADDR;
                end else begin
                    free_ok = 1'b1;
                end
            end
            default: res_status = ST_OK;
        endcase
    end

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_free   = r_free;
        n_in_use = r_in_use;
        n_base   = r_base;
        n_cnt    = r_cnt;
        if (i_cmd.exec) begin
            case (r_op)
                OP_INIT: begin
                    n_base   = (r_start + 32'(CHUNK_BYTES)) & ALIGN_MASK;
                    n_in_use = n_init;
                    n_head   = '0;
                    n_tail   = (n_init != '0) ? IW'(n_init - CW'(1)) : '0;
                    n_free   = (n_init != '0) ? n_init - CW'(1) : '0;
                    n_cnt    = '0;
                end
                OP_ALLOC: begin
                    if (alloc_ok) begin
                        n_head = rdata;
                        n_free = r_free - CW'(1);
                    end
                end
                OP_FREE: begin
                    if (free_ok) begin
                        n_tail = idx32[IW-1:0];
                        if (r_free < CW'(MAX_CHUNKS)) begin
                            n_free = r_free + CW'(1);
                        end
                    end
                end
                default: n_head = r_head;
            endcase
        end
        if (i_cmd.walk) begin
            n_cnt = r_cnt + CW'(1);
        end
    end

    // link store write: init sweep or append at the tail
    always_comb begin
        cnt_inc   = r_cnt + CW'(1);
        link_val  = (cnt_inc < CW'(MAX_CHUNKS)) ? cnt_inc[IW-1:0] : '0;
        mem_we    = i_cmd.walk || (i_cmd.exec && free_ok && (r_op == OP_FREE));
        mem_waddr = i_cmd.walk ? r_cnt[IW-1:0] : r_tail;
        mem_wdata = i_cmd.walk ? link_val : idx32[IW-1:0];
    end

    // read port tracks the head, so the head link is registered on the accept edge
    fcfl_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_CHUNKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_head),
        .o_rdata (rdata)
    );

    assign o_stat.is_init   = (r_op == OP_INIT);
    assign o_stat.walk_done = (r_cnt == r_in_use);
    assign o_chunk_addr     = r_out_addr;
    assign o_status         = r_out_status;
    assign o_free_count     = r_out_free;

endmodule

// ===== rtl/core/fcfl_ctrl.sv =====
module fcfl_ctrl import fcfl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_WALK = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_init) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_WALK;
                end else if (slot_free) begin
                    o_cmd.exec = 1'b1;
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_WALK: begin
                if (!i_stat.walk_done) begin
                    o_cmd.walk = 1'b1;
                end else if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/fixed_chunk_free_list_allocator_top.sv =====
// Channel   Handshake                   Beat
// config    i_cfg_we                    i_cfg_idx, i_cfg_wdata
// request   i_in_valid / o_in_ready     i_opcode, i_request_size, i_release_addr
// result    o_out_valid / i_out_ready   o_chunk_addr, o_status, o_free_count
//
// Alloc, free and no-op: accept, then execute once the output slot is free; the
// head link is read from the link RAM on the accept edge, needing no read state.
// Init then sweeps n chunks: the link RAM is written one entry a cycle.
// Reset clears list pointers, free and in-use counts and config; the link RAM is not cleared.
// A result waits in the output register; one more beat is accepted meanwhile.
module fixed_chunk_free_list_allocator_top import fcfl_pkg::*; #(
    parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [31:0]                     i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_opcode,
    input  logic signed [31:0]              i_request_size,
    input  logic [31:0]                     i_release_addr,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [31:0]                     o_chunk_addr,
    output logic [2:0]                      o_status,
    output logic [$clog2(MAX_CHUNKS+1)-1:0] o_free_count
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    fcfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fcfl_dp #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_opcode       (i_opcode),
        .i_request_size ($unsigned(i_request_size)),
        .i_release_addr (i_release_addr),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_chunk_addr   (o_chunk_addr),
        .o_status       (o_status),
        .o_free_count   (o_free_count)
    );

endmodule

// ===== rtl/core/fcfl_checker.sv =====
`include "fixed_chunk_free_list_allocator_top_macros.svh"

module fcfl_checker import fcfl_pkg::*; #(
    parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [31:0]                     o_chunk_addr,
    input logic [2:0]                      o_status,
    input logic [$clog2(MAX_CHUNKS+1)-1:0] o_free_count
);

    logic [2:0] r_pending, n_pending;
    logic       in_beat, out_beat;

    assign in_beat  = i_in_valid && o_in_ready;
    assign out_beat = o_out_valid && i_out_ready;

    // requests accepted but not yet delivered
    always_comb begin
        n_pending = r_pending;
        if (in_beat && !out_beat) begin
            n_pending = r_pending + 3'd1;
        end else if (out_beat && !in_beat) begin
            n_pending = r_pending - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    `FCFL_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_chunk_addr) && $stable(o_status) && $stable(o_free_count), "result dropped or changed while stalled")
    `FCFL_NEVER(a_no_phantom, o_out_valid && (r_pending == 3'd0), "result without a pending request")
    `FCFL_NEVER(a_pending_bound, r_pending > 3'd2, "more than two requests in flight")
    `FCFL_NEVER(a_fail_addr, o_out_valid && (o_status != ST_OK) && (o_chunk_addr != 32'd0), "failed request returned an address")
    `FCFL_NEVER(a_count_bound, o_out_valid && (32'(o_free_count) > 32'(MAX_CHUNKS)), "free count above capacity")

endmodule

bind fixed_chunk_free_list_allocator_top fcfl_checker #(
    .MAX_CHUNKS (MAX_CHUNKS)
) u_fcfl_checker (.*);
